// ----- src/hllc_pkg.sv -----
// types, constants, micro-code and fixed-point helpers for the hll/hllc riemann flux block
`default_nettype none
package hllc_pkg;

  localparam int WORD_BITS      = 48;
  localparam int FRAC_BITS      = 24;
  localparam int NUM_COMPONENTS = 8;
  localparam int HALF_BITS      = WORD_BITS / 2;
  localparam int PROD_BITS      = 2 * WORD_BITS;
  localparam int DVD_BITS       = WORD_BITS + FRAC_BITS;
  localparam int DIV_CNT_W      = $clog2(DVD_BITS);
  localparam int PC_W           = 7;
  localparam int COMP_W         = 3;
  localparam int TMP_W          = 4;
  localparam int MEM_BITS       = 4 * WORD_BITS;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [WORD_BITS-1:0]        umag_t;
  typedef logic [PC_W-1:0]             pc_t;
  typedef logic [TMP_W-1:0]            tmp_t;
  typedef logic [5:0]                  opnd_t;

  localparam word_t SMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t SMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [PROD_BITS-1:0] MAG_MAX = PROD_BITS'(SMAX);
  localparam logic [PROD_BITS-1:0] MAG_MIN = MAG_MAX + PROD_BITS'(1);
  localparam word_t ONE = word_t'(PROD_BITS'(1) << FRAC_BITS);

  localparam logic [1:0] OPC_LEFT  = 2'd0;
  localparam logic [1:0] OPC_RIGHT = 2'd1;
  localparam logic [1:0] OPC_COMP  = 2'd2;

  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_NX   = 2'd1;
  localparam logic [1:0] CFG_NY   = 2'd2;
  localparam logic [1:0] CFG_NZ   = 2'd3;

  localparam logic [COMP_W-1:0] LAST_Q = COMP_W'(NUM_COMPONENTS - 1);
  localparam logic [COMP_W-1:0] Q_DENS = 3'd0;
  localparam logic [COMP_W-1:0] Q_ENER = 3'd1;
  localparam logic [COMP_W-1:0] Q_MX   = 3'd2;
  localparam logic [COMP_W-1:0] Q_MY   = 3'd3;
  localparam logic [COMP_W-1:0] Q_MZ   = 3'd4;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [COMP_W-1:0] component;
    word_t             cons_left;
    word_t             cons_right;
    word_t             flux_left;
    word_t             flux_right;
    word_t             density;
    word_t             pressure;
    word_t             vel_x;
    word_t             vel_y;
    word_t             vel_z;
    word_t             wave_speed;
  } in_word_t;

  typedef struct packed {
    logic [COMP_W-1:0] out_component;
    word_t             state_value;
    word_t             flux_value;
    logic              degenerate;
    logic              last;
  } out_word_t;

  typedef enum logic [1:0] {ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV} alu_op_t;

  typedef struct packed {
    logic    last;
    alu_op_t op;
    tmp_t    dst;
    opnd_t   a;
    opnd_t   b;
  } instr_t;

  // operand codes: temporaries first
  localparam opnd_t O_T0 = 6'd0,  O_T1 = 6'd1,  O_T2 = 6'd2,  O_T3 = 6'd3;
  localparam opnd_t O_T4 = 6'd4,  O_T5 = 6'd5,  O_T6 = 6'd6;
  localparam opnd_t O_T9 = 6'd9,  O_T10 = 6'd10, O_T11 = 6'd11, O_T12 = 6'd12;
  localparam opnd_t O_T13 = 6'd13, O_T14 = 6'd14;
  localparam opnd_t O_L0 = 6'd16, O_L1 = 6'd17, O_L2 = 6'd18, O_L3 = 6'd19;
  localparam opnd_t O_L4 = 6'd20, O_L5 = 6'd21;
  localparam opnd_t O_R0 = 6'd22, O_R1 = 6'd23, O_R2 = 6'd24, O_R3 = 6'd25;
  localparam opnd_t O_R4 = 6'd26, O_R5 = 6'd27;
  localparam opnd_t O_S0 = 6'd28, O_S1 = 6'd29, O_S2 = 6'd30, O_S3 = 6'd31;
  localparam opnd_t O_S4 = 6'd32, O_S5 = 6'd33;
  localparam opnd_t O_SVQ = 6'd34, O_NQ = 6'd35;
  localparam opnd_t O_NX = 6'd36, O_NY = 6'd37, O_NZ = 6'd38;
  localparam opnd_t O_UL = 6'd39, O_UR = 6'd40, O_FL = 6'd41, O_FR = 6'd42;
  localparam opnd_t O_US = 6'd43, O_FS = 6'd44, O_ZERO = 6'd45;

  localparam tmp_t T0 = 4'd0, T1 = 4'd1, T2 = 4'd2, T3 = 4'd3, T4 = 4'd4;
  localparam tmp_t T5 = 4'd5, T6 = 4'd6, T_QN = 4'd9, T_E = 4'd10;
  localparam tmp_t T_DS = 4'd11, T_SM = 4'd12, T_DEN = 4'd13;
  localparam tmp_t T_SU = 4'd14, T_SF = 4'd15;

  localparam pc_t PC_HLLE_PRE  = 7'd0;
  localparam pc_t PC_HLLE_Q    = 7'd1;
  localparam pc_t PC_PASS      = 7'd15;
  localparam pc_t PC_HLLC_PRE  = 7'd17;
  localparam pc_t PC_STAR_PRE  = 7'd40;
  localparam pc_t PC_STAR0     = 7'd55;
  localparam pc_t PC_STAR1     = 7'd59;
  localparam pc_t PC_STARV     = 7'd63;
  localparam pc_t PC_STARF     = 7'd71;

  function automatic instr_t mk(logic last, alu_op_t op, tmp_t dst, opnd_t a, opnd_t b);
    instr_t i;
    i.last = last;
    i.op   = op;
    i.dst  = dst;
    i.a    = a;
    i.b    = b;
    return i;
  endfunction

  function automatic instr_t ucode(pc_t pc);
    instr_t i;
    case (pc)
      // hlle: wave speed difference
      7'd0:  i = mk(1'b1, ALU_SUB, T_DEN, O_R5, O_L5);
      // hlle: per component state and flux
      7'd1:  i = mk(1'b0, ALU_MUL, T0, O_R5, O_UR);
      7'd2:  i = mk(1'b0, ALU_MUL, T1, O_L5, O_UL);
      7'd3:  i = mk(1'b0, ALU_SUB, T0, O_T0, O_T1);
      7'd4:  i = mk(1'b0, ALU_SUB, T1, O_FL, O_FR);
      7'd5:  i = mk(1'b0, ALU_ADD, T0, O_T0, O_T1);
      7'd6:  i = mk(1'b0, ALU_DIV, T_SU, O_T0, O_T13);
      7'd7:  i = mk(1'b0, ALU_MUL, T0, O_R5, O_FL);
      7'd8:  i = mk(1'b0, ALU_MUL, T1, O_L5, O_FR);
      7'd9:  i = mk(1'b0, ALU_SUB, T0, O_T0, O_T1);
      7'd10: i = mk(1'b0, ALU_MUL, T1, O_R5, O_L5);
      7'd11: i = mk(1'b0, ALU_SUB, T2, O_UR, O_UL);
      7'd12: i = mk(1'b0, ALU_MUL, T1, O_T1, O_T2);
      7'd13: i = mk(1'b0, ALU_ADD, T0, O_T0, O_T1);
      7'd14: i = mk(1'b1, ALU_DIV, T_SF, O_T0, O_T13);
      // outer region pass-through
      7'd15: i = mk(1'b0, ALU_ADD, T_SU, O_US, O_ZERO);
      7'd16: i = mk(1'b1, ALU_ADD, T_SF, O_FS, O_ZERO);
      // hllc: normal speeds, contact speed
      7'd17: i = mk(1'b0, ALU_MUL, T0, O_L2, O_NX);
      7'd18: i = mk(1'b0, ALU_MUL, T1, O_L3, O_NY);
      7'd19: i = mk(1'b0, ALU_ADD, T0, O_T0, O_T1);
      7'd20: i = mk(1'b0, ALU_MUL, T1, O_L4, O_NZ);
      7'd21: i = mk(1'b0, ALU_ADD, T0, O_T0, O_T1);
      7'd22: i = mk(1'b0, ALU_MUL, T1, O_R2, O_NX);
      7'd23: i = mk(1'b0, ALU_MUL, T2, O_R3, O_NY);
      7'd24: i = mk(1'b0, ALU_ADD, T1, O_T1, O_T2);
      7'd25: i = mk(1'b0, ALU_MUL, T2, O_R4, O_NZ);
      7'd26: i = mk(1'b0, ALU_ADD, T1, O_T1, O_T2);
      7'd27: i = mk(1'b0, ALU_SUB, T2, O_L5, O_T0);
      7'd28: i = mk(1'b0, ALU_SUB, T3, O_R5, O_T1);
      7'd29: i = mk(1'b0, ALU_MUL, T4, O_R0, O_T1);
      7'd30: i = mk(1'b0, ALU_MUL, T4, O_T4, O_T3);
      7'd31: i = mk(1'b0, ALU_MUL, T5, O_L0, O_T0);
      7'd32: i = mk(1'b0, ALU_MUL, T5, O_T5, O_T2);
      7'd33: i = mk(1'b0, ALU_SUB, T4, O_T4, O_T5);
      7'd34: i = mk(1'b0, ALU_SUB, T5, O_L1, O_R1);
      7'd35: i = mk(1'b0, ALU_ADD, T4, O_T4, O_T5);
      7'd36: i = mk(1'b0, ALU_MUL, T5, O_R0, O_T3);
      7'd37: i = mk(1'b0, ALU_MUL, T6, O_L0, O_T2);
      7'd38: i = mk(1'b0, ALU_SUB, T5, O_T5, O_T6);
      7'd39: i = mk(1'b1, ALU_DIV, T_SM, O_T4, O_T5);
      // star region common terms
      7'd40: i = mk(1'b0, ALU_MUL, T_QN, O_S2, O_NX);
      7'd41: i = mk(1'b0, ALU_MUL, T0, O_S3, O_NY);
      7'd42: i = mk(1'b0, ALU_ADD, T_QN, O_T9, O_T0);
      7'd43: i = mk(1'b0, ALU_MUL, T0, O_S4, O_NZ);
      7'd44: i = mk(1'b0, ALU_ADD, T_QN, O_T9, O_T0);
      7'd45: i = mk(1'b0, ALU_SUB, T0, O_S5, O_T9);
      7'd46: i = mk(1'b0, ALU_MUL, T1, O_S0, O_T0);
      7'd47: i = mk(1'b0, ALU_SUB, T2, O_S5, O_T12);
      7'd48: i = mk(1'b0, ALU_DIV, T_DS, O_T1, O_T2);
      7'd49: i = mk(1'b0, ALU_DIV, T3, O_US, O_S0);
      7'd50: i = mk(1'b0, ALU_DIV, T4, O_S1, O_T1);
      7'd51: i = mk(1'b0, ALU_ADD, T4, O_T12, O_T4);
      7'd52: i = mk(1'b0, ALU_SUB, T5, O_T12, O_T9);
      7'd53: i = mk(1'b0, ALU_MUL, T5, O_T5, O_T4);
      7'd54: i = mk(1'b1, ALU_ADD, T_E, O_T3, O_T5);
      // star density
      7'd55: i = mk(1'b0, ALU_ADD, T_SU, O_T11, O_ZERO);
      7'd56: i = mk(1'b0, ALU_SUB, T0, O_T14, O_US);
      7'd57: i = mk(1'b0, ALU_MUL, T0, O_S5, O_T0);
      7'd58: i = mk(1'b1, ALU_ADD, T_SF, O_FS, O_T0);
      // star energy
      7'd59: i = mk(1'b0, ALU_MUL, T_SU, O_T11, O_T10);
      7'd60: i = mk(1'b0, ALU_SUB, T0, O_T14, O_US);
      7'd61: i = mk(1'b0, ALU_MUL, T0, O_S5, O_T0);
      7'd62: i = mk(1'b1, ALU_ADD, T_SF, O_FS, O_T0);
      // star momentum
      7'd63: i = mk(1'b0, ALU_MUL, T0, O_T12, O_NQ);
      7'd64: i = mk(1'b0, ALU_MUL, T1, O_T9, O_NQ);
      7'd65: i = mk(1'b0, ALU_SUB, T1, O_SVQ, O_T1);
      7'd66: i = mk(1'b0, ALU_ADD, T0, O_T0, O_T1);
      7'd67: i = mk(1'b0, ALU_MUL, T_SU, O_T11, O_T0);
      7'd68: i = mk(1'b0, ALU_SUB, T0, O_T14, O_US);
      7'd69: i = mk(1'b0, ALU_MUL, T0, O_S5, O_T0);
      7'd70: i = mk(1'b1, ALU_ADD, T_SF, O_FS, O_T0);
      // star field components are zero
      7'd71: i = mk(1'b0, ALU_ADD, T_SU, O_ZERO, O_ZERO);
      7'd72: i = mk(1'b0, ALU_SUB, T0, O_T14, O_US);
      7'd73: i = mk(1'b0, ALU_MUL, T0, O_S5, O_T0);
      7'd74: i = mk(1'b1, ALU_ADD, T_SF, O_FS, O_T0);
      default: i = mk(1'b1, ALU_ADD, T0, O_ZERO, O_ZERO);
    endcase
    return i;
  endfunction

  function automatic umag_t mag(word_t x);
    return x[WORD_BITS-1] ? umag_t'(-x) : umag_t'(x);
  endfunction

  function automatic word_t from_mag(logic [PROD_BITS-1:0] m, logic neg);
    if (neg) begin
      if (m > MAG_MIN) return SMIN;
      return word_t'(-m[WORD_BITS-1:0]);
    end
    if (m > MAG_MAX) return SMAX;
    return word_t'(m[WORD_BITS-1:0]);
  endfunction

  function automatic word_t sat_addsub(word_t a, word_t b, logic sub);
    logic signed [WORD_BITS:0] s;
    if (sub) s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    else     s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? SMIN : SMAX;
    return word_t'(s[WORD_BITS-1:0]);
  endfunction

endpackage
`default_nettype wire

// ----- src/hll_hllc_riemann_flux.sv -----
// top level of the hlle/hllc riemann flux block: stores, micro-coded datapath, output register
//
//   channel | ports                              | direction | handshake
//   in      | in_valid, in_stall, in_data        | input     | valid / stall
//   out     | out_valid, out_stall, out_data     | output    | valid / stall
//   cfg     | cfg_valid, cfg_ready, cfg_index/data| input    | valid / ready
//
// the last component load starts a solve of one shared alu driven by a micro-code rom;
// each instruction is issued and executed: add/sub finish in execute, multiply sums
// four 24x24 partial products and divide shifts in one quotient bit per cycle, both then
// writing back; each component is read before its steps and emitted after its result
// rst_n clears control and loads the register reset values; stores need no clearing
// in_stall is high for the whole solve; out_stall holds the output word and the solve
// may run ahead by one result
`default_nettype none
module hll_hllc_riemann_flux (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic in_valid,
  output                     logic in_stall,
  input  wire hllc_pkg::in_word_t in_data,
  output                     logic out_valid,
  input  wire                logic out_stall,
  output hllc_pkg::out_word_t     out_data,
  input  wire                logic cfg_valid,
  output                     logic cfg_ready,
  input  wire          logic [1:0] cfg_index,
  input  wire hllc_pkg::word_t    cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RD    = 8'b0000_0010,
    S_ISSUE = 8'b0000_0100,
    S_EXEC  = 8'b0000_1000,
    S_MUL   = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_WB    = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  typedef enum logic [1:0] {CTX_HLLE_PRE, CTX_HLLC_PRE, CTX_STAR_PRE, CTX_COMP} ctx_t;
  typedef enum logic [1:0] {K_HLLE, K_PASS, K_STAR} kind_t;

  state_t state_r, state_nxt;
  ctx_t   ctx_r, ctx_nxt;
  kind_t  kind_r, kind_nxt;
  logic   side_r, side_nxt;
  logic   deg_r, deg_nxt;
  hllc_pkg::pc_t pc_r, pc_nxt;
  logic [hllc_pkg::COMP_W-1:0] q_r, q_nxt;

  logic mode_r;
  hllc_pkg::word_t nx_r, ny_r, nz_r;
  hllc_pkg::word_t l_prim_r [0:5];
  hllc_pkg::word_t r_prim_r [0:5];
  hllc_pkg::word_t s_prim [0:5];

  logic [hllc_pkg::MEM_BITS-1:0] cs_mem [0:hllc_pkg::NUM_COMPONENTS-1];
  logic [hllc_pkg::MEM_BITS-1:0] rd_r;
  hllc_pkg::word_t tmp_mem [0:(1<<hllc_pkg::TMP_W)-1];
  hllc_pkg::word_t rda_r, rdb_r;

  hllc_pkg::umag_t ma_r, mb_r;
  logic neg_r;
  logic [hllc_pkg::PROD_BITS-1:0] acc_r;
  logic [1:0] mul_cnt_r;
  logic [hllc_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic [hllc_pkg::WORD_BITS-1:0] rem_r;
  logic [hllc_pkg::DVD_BITS-1:0] dvd_r, quot_r;
  hllc_pkg::word_t su_r, sf_r;

  logic out_valid_r;
  hllc_pkg::out_word_t out_data_r;

  hllc_pkg::instr_t ins;
  hllc_pkg::word_t  a_val, b_val, res, ul, ur, fl, fr;
  logic done, in_acc, out_free, emit;
  logic [hllc_pkg::HALF_BITS-1:0] pa, pb;
  logic [hllc_pkg::WORD_BITS-1:0] pp;
  logic [hllc_pkg::PROD_BITS-1:0] pp_sh;
  logic [hllc_pkg::WORD_BITS:0] rem_sh;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign emit      = (state_r == S_EMIT) && out_free;
  assign ins       = hllc_pkg::ucode(pc_r);

  assign ul = rd_r[4*hllc_pkg::WORD_BITS-1:3*hllc_pkg::WORD_BITS];
  assign ur = rd_r[3*hllc_pkg::WORD_BITS-1:2*hllc_pkg::WORD_BITS];
  assign fl = rd_r[2*hllc_pkg::WORD_BITS-1:hllc_pkg::WORD_BITS];
  assign fr = rd_r[hllc_pkg::WORD_BITS-1:0];

  always_comb begin
    for (int i = 0; i < 6; i++) s_prim[i] = side_r ? r_prim_r[i] : l_prim_r[i];
  end

  function automatic hllc_pkg::word_t opnd_val(hllc_pkg::opnd_t o, hllc_pkg::word_t trd);
    hllc_pkg::word_t v;
    v = '0;
    if (o < hllc_pkg::O_L0) begin
      v = trd;
    end else begin
      case (o)
        hllc_pkg::O_L0:  v = l_prim_r[0];
        hllc_pkg::O_L1:  v = l_prim_r[1];
        hllc_pkg::O_L2:  v = l_prim_r[2];
        hllc_pkg::O_L3:  v = l_prim_r[3];
        hllc_pkg::O_L4:  v = l_prim_r[4];
        hllc_pkg::O_L5:  v = l_prim_r[5];
        hllc_pkg::O_R0:  v = r_prim_r[0];
        hllc_pkg::O_R1:  v = r_prim_r[1];
        hllc_pkg::O_R2:  v = r_prim_r[2];
        hllc_pkg::O_R3:  v = r_prim_r[3];
        hllc_pkg::O_R4:  v = r_prim_r[4];
        hllc_pkg::O_R5:  v = r_prim_r[5];
        hllc_pkg::O_S0:  v = s_prim[0];
        hllc_pkg::O_S1:  v = s_prim[1];
        hllc_pkg::O_S2:  v = s_prim[2];
        hllc_pkg::O_S3:  v = s_prim[3];
        hllc_pkg::O_S4:  v = s_prim[4];
        hllc_pkg::O_S5:  v = s_prim[5];
        hllc_pkg::O_SVQ: begin
          case (q_r)
            hllc_pkg::Q_MX: v = s_prim[2];
            hllc_pkg::Q_MY: v = s_prim[3];
            hllc_pkg::Q_MZ: v = s_prim[4];
            default:        v = '0;
          endcase
        end
        hllc_pkg::O_NQ: begin
          case (q_r)
            hllc_pkg::Q_MX: v = nx_r;
            hllc_pkg::Q_MY: v = ny_r;
            hllc_pkg::Q_MZ: v = nz_r;
            default:        v = '0;
          endcase
        end
        hllc_pkg::O_NX:  v = nx_r;
        hllc_pkg::O_NY:  v = ny_r;
        hllc_pkg::O_NZ:  v = nz_r;
        hllc_pkg::O_UL:  v = ul;
        hllc_pkg::O_UR:  v = ur;
        hllc_pkg::O_FL:  v = fl;
        hllc_pkg::O_FR:  v = fr;
        hllc_pkg::O_US:  v = side_r ? ur : ul;
        hllc_pkg::O_FS:  v = side_r ? fr : fl;
        default:         v = '0;
      endcase
    end
    return v;
  endfunction

  always_comb begin
    a_val = opnd_val(ins.a, rda_r);
    b_val = opnd_val(ins.b, rdb_r);
  end

  // one 24x24 partial product per cycle
  assign pa = mul_cnt_r[1] ? ma_r[hllc_pkg::WORD_BITS-1:hllc_pkg::HALF_BITS]
                           : ma_r[hllc_pkg::HALF_BITS-1:0];
  assign pb = mul_cnt_r[0] ? mb_r[hllc_pkg::WORD_BITS-1:hllc_pkg::HALF_BITS]
                           : mb_r[hllc_pkg::HALF_BITS-1:0];
  assign pp = hllc_pkg::WORD_BITS'(pa) * hllc_pkg::WORD_BITS'(pb);
  always_comb begin
    unique case (mul_cnt_r)
      2'd0:    pp_sh = hllc_pkg::PROD_BITS'(pp);
      2'd3:    pp_sh = hllc_pkg::PROD_BITS'(pp) << (2 * hllc_pkg::HALF_BITS);
      default: pp_sh = hllc_pkg::PROD_BITS'(pp) << hllc_pkg::HALF_BITS;
    endcase
  end

  assign rem_sh = {rem_r, dvd_r[hllc_pkg::DVD_BITS-1]};

  always_comb begin
    state_nxt = state_r;
    ctx_nxt   = ctx_r;
    kind_nxt  = kind_r;
    side_nxt  = side_r;
    deg_nxt   = deg_r;
    pc_nxt    = pc_r;
    q_nxt     = q_r;
    done      = 1'b0;
    res       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_data.opcode == hllc_pkg::OPC_COMP &&
            in_data.component == hllc_pkg::LAST_Q) begin
          deg_nxt = 1'b0;
          q_nxt   = '0;
          if (!mode_r) begin
            kind_nxt  = K_HLLE;
            ctx_nxt   = CTX_HLLE_PRE;
            pc_nxt    = hllc_pkg::PC_HLLE_PRE;
            state_nxt = S_ISSUE;
          end else if (!l_prim_r[5][hllc_pkg::WORD_BITS-1]) begin
            kind_nxt  = K_PASS;
            side_nxt  = 1'b0;
            ctx_nxt   = CTX_COMP;
            state_nxt = S_RD;
          end else begin
            kind_nxt  = K_STAR;
            ctx_nxt   = CTX_HLLC_PRE;
            pc_nxt    = hllc_pkg::PC_HLLC_PRE;
            state_nxt = S_ISSUE;
          end
        end
      end
      S_RD: begin
        state_nxt = S_ISSUE;
        if (ctx_r == CTX_STAR_PRE) begin
          pc_nxt = hllc_pkg::PC_STAR_PRE;
        end else begin
          unique case (kind_r)
            K_HLLE: pc_nxt = hllc_pkg::PC_HLLE_Q;
            K_PASS: pc_nxt = hllc_pkg::PC_PASS;
            default: begin
              if (q_r == hllc_pkg::Q_DENS)      pc_nxt = hllc_pkg::PC_STAR0;
              else if (q_r == hllc_pkg::Q_ENER) pc_nxt = hllc_pkg::PC_STAR1;
              else if (q_r <= hllc_pkg::Q_MZ)   pc_nxt = hllc_pkg::PC_STARV;
              else                              pc_nxt = hllc_pkg::PC_STARF;
            end
          endcase
        end
      end
      S_ISSUE: state_nxt = S_EXEC;
      S_EXEC: begin
        unique case (ins.op)
          hllc_pkg::ALU_ADD, hllc_pkg::ALU_SUB: begin
            done = 1'b1;
            res  = hllc_pkg::sat_addsub(a_val, b_val, ins.op == hllc_pkg::ALU_SUB);
          end
          hllc_pkg::ALU_MUL: state_nxt = S_MUL;
          default: begin
            if (b_val == '0) begin
              done    = 1'b1;
              deg_nxt = 1'b1;
              if (a_val == '0)                       res = '0;
              else if (a_val[hllc_pkg::WORD_BITS-1]) res = hllc_pkg::SMIN;
              else                                   res = hllc_pkg::SMAX;
            end else begin
              state_nxt = S_DIV;
            end
          end
        endcase
      end
      S_MUL: if (mul_cnt_r == 2'd3) state_nxt = S_WB;
      S_DIV: begin
        if (div_cnt_r == hllc_pkg::DIV_CNT_W'(hllc_pkg::DVD_BITS - 1)) state_nxt = S_WB;
      end
      S_WB: begin
        done = 1'b1;
        if (ins.op == hllc_pkg::ALU_MUL)
          res = hllc_pkg::from_mag(acc_r >> hllc_pkg::FRAC_BITS, neg_r);
        else
          res = hllc_pkg::from_mag(hllc_pkg::PROD_BITS'(quot_r), neg_r);
      end
      default: begin
        if (out_free) begin
          if (q_r == hllc_pkg::LAST_Q) begin
            state_nxt = S_IDLE;
          end else begin
            q_nxt     = q_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
    endcase

    if (done) begin
      if (!ins.last) begin
        pc_nxt    = pc_r + 1'b1;
        state_nxt = S_ISSUE;
      end else begin
        unique case (ctx_r)
          CTX_HLLC_PRE: begin
            state_nxt = S_RD;
            if (!res[hllc_pkg::WORD_BITS-1] || !r_prim_r[5][hllc_pkg::WORD_BITS-1]) begin
              side_nxt = res[hllc_pkg::WORD_BITS-1];
              kind_nxt = K_STAR;
              ctx_nxt  = CTX_STAR_PRE;
              q_nxt    = hllc_pkg::Q_ENER;
            end else begin
              side_nxt = 1'b1;
              kind_nxt = K_PASS;
              ctx_nxt  = CTX_COMP;
              q_nxt    = '0;
            end
          end
          CTX_HLLE_PRE, CTX_STAR_PRE: begin
            state_nxt = S_RD;
            ctx_nxt   = CTX_COMP;
            q_nxt     = '0;
          end
          default: state_nxt = S_EMIT;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ctx_r       <= CTX_COMP;
      kind_r      <= K_HLLE;
      side_r      <= 1'b0;
      deg_r       <= 1'b0;
      pc_r        <= '0;
      q_r         <= '0;
      out_valid_r <= 1'b0;
      mode_r      <= 1'b1;
      nx_r        <= hllc_pkg::ONE;
      ny_r        <= '0;
      nz_r        <= '0;
    end else begin
      state_r <= state_nxt;
      ctx_r   <= ctx_nxt;
      kind_r  <= kind_nxt;
      side_r  <= side_nxt;
      deg_r   <= deg_nxt;
      pc_r    <= pc_nxt;
      q_r     <= q_nxt;
      if (emit)            out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          hllc_pkg::CFG_MODE: mode_r <= cfg_data[0];
          hllc_pkg::CFG_NX:   nx_r   <= cfg_data;
          hllc_pkg::CFG_NY:   ny_r   <= cfg_data;
          default:            nz_r   <= cfg_data;
        endcase
      end
    end
  end

  // stores and primitive registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (in_data.opcode == hllc_pkg::OPC_COMP) begin
        cs_mem[in_data.component] <= {in_data.cons_left, in_data.cons_right,
                                      in_data.flux_left, in_data.flux_right};
      end else if (in_data.opcode == hllc_pkg::OPC_LEFT) begin
        l_prim_r[0] <= in_data.density;
        l_prim_r[1] <= in_data.pressure;
        l_prim_r[2] <= in_data.vel_x;
        l_prim_r[3] <= in_data.vel_y;
        l_prim_r[4] <= in_data.vel_z;
        l_prim_r[5] <= in_data.wave_speed;
      end else if (in_data.opcode == hllc_pkg::OPC_RIGHT) begin
        r_prim_r[0] <= in_data.density;
        r_prim_r[1] <= in_data.pressure;
        r_prim_r[2] <= in_data.vel_x;
        r_prim_r[3] <= in_data.vel_y;
        r_prim_r[4] <= in_data.vel_z;
        r_prim_r[5] <= in_data.wave_speed;
      end
    end
    rd_r <= cs_mem[q_r];
  end

  // temporaries and arithmetic unit
  always_ff @(posedge clk) begin
    if (done) tmp_mem[ins.dst] <= res;
    rda_r <= tmp_mem[ins.a[hllc_pkg::TMP_W-1:0]];
    rdb_r <= tmp_mem[ins.b[hllc_pkg::TMP_W-1:0]];
    if (done && ins.dst == hllc_pkg::T_SU) su_r <= res;
    if (done && ins.dst == hllc_pkg::T_SF) sf_r <= res;
    if (state_r == S_EXEC) begin
      ma_r      <= hllc_pkg::mag(a_val);
      mb_r      <= hllc_pkg::mag(b_val);
      neg_r     <= a_val[hllc_pkg::WORD_BITS-1] ^ b_val[hllc_pkg::WORD_BITS-1];
      acc_r     <= '0;
      mul_cnt_r <= '0;
      div_cnt_r <= '0;
      rem_r     <= '0;
      dvd_r     <= {hllc_pkg::mag(a_val), {hllc_pkg::FRAC_BITS{1'b0}}};
      quot_r    <= '0;
    end
    if (state_r == S_MUL) begin
      acc_r     <= acc_r + pp_sh;
      mul_cnt_r <= mul_cnt_r + 1'b1;
    end
    if (state_r == S_DIV) begin
      if (rem_sh >= {1'b0, mb_r}) begin
        rem_r  <= hllc_pkg::WORD_BITS'(rem_sh - {1'b0, mb_r});
        quot_r <= {quot_r[hllc_pkg::DVD_BITS-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[hllc_pkg::WORD_BITS-1:0];
        quot_r <= {quot_r[hllc_pkg::DVD_BITS-2:0], 1'b0};
      end
      dvd_r     <= {dvd_r[hllc_pkg::DVD_BITS-2:0], 1'b0};
      div_cnt_r <= div_cnt_r + 1'b1;
    end
    if (emit) begin
      out_data_r.out_component <= q_r;
      out_data_r.state_value   <= su_r;
      out_data_r.flux_value    <= sf_r;
      out_data_r.degenerate    <= deg_r;
      out_data_r.last          <= (q_r == hllc_pkg::LAST_Q);
    end
  end

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && q_r == hllc_pkg::LAST_Q) |=> state_r == S_IDLE)
    else $error("solve did not end after the last word");

  a_deg_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |=> $stable(deg_r))
    else $error("degenerate flag changed during emission");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> mb_r != '0)
    else $error("divider running on a zero divisor");

  a_no_emit_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(out_data_r))
    else $error("pending result overwritten");

endmodule
`default_nettype wire
